/* src/button_debounce_short_long_press_assert.svh */
// ----------------------------------------------------------------------------
// button debounce assertion macros
// shared concurrent assertion forms, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BDSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdsl assertion failed");

// next-cycle implication
`define BDSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdsl assertion failed");

`endif

/* src/bdsl_pkg.sv */
// ----------------------------------------------------------------------------
// bdsl_pkg
// shared constants, types and helpers of the button debounce block
// ----------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

    localparam int BUTTONS    = 3;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CODE_BITS  = 2;
    localparam int CODED_BUTTONS = 3;
    localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    typedef logic [COUNT_BITS-1:0]   t_cnt;
    typedef logic [CMP_BITS-1:0]     t_cmp;
    typedef logic [CFG_BITS-1:0]     t_cfg_word;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [BUTTONS-1:0]      t_btn_vec;
    typedef logic [CODE_BITS-1:0]    t_code;

    localparam t_cfg_idx CFG_DEBOUNCE   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_LONG_PRESS = t_cfg_idx'(1);

    localparam t_cfg_word DEBOUNCE_RESET   = t_cfg_word'(50);
    localparam t_cfg_word LONG_PRESS_RESET = t_cfg_word'(1000);

    localparam t_code CODE_NONE = t_code'(0);

    localparam t_cnt CNT_MAX = '1;

    typedef struct packed {
        t_cfg_word debounce_ticks;
        t_cfg_word long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic short_pulse;
        logic long_pulse;
        logic level;
    } t_btn_evt;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? CNT_MAX : v + t_cnt'(1);
    endfunction

endpackage

`default_nettype wire

/* src/bdsl_if.sv */
// ----------------------------------------------------------------------------
// bdsl channel interfaces
// valid/ready channels for the raw sample word and the press event word
// ----------------------------------------------------------------------------
`default_nettype none

interface bdsl_in_if;
    logic                      valid;
    logic                      ready;
    logic [bdsl_pkg::BUTTONS-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bdsl_out_if;
    logic                          valid;
    logic                          ready;
    logic [bdsl_pkg::BUTTONS-1:0]   short_press;
    logic [bdsl_pkg::BUTTONS-1:0]   long_press;
    logic [bdsl_pkg::CODE_BITS-1:0] pressed_code;

    modport source (output valid, output short_press, output long_press,
                    output pressed_code, input ready);
    modport sink   (input valid, input short_press, input long_press,
                    input pressed_code, output ready);
endinterface

`default_nettype wire

/* src/bdsl_button.sv */
// ----------------------------------------------------------------------------
// bdsl_button
// per-button debounce filter with hold timer and short/long press pulses
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_short_long_press_assert.svh"

module bdsl_button (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_raw,
    input  wire bdsl_pkg::t_cfg     i_cfg,
    output bdsl_pkg::t_btn_evt      o_evt
);

    logic           r_last_raw, n_last_raw;
    logic           r_level, n_level;
    bdsl_pkg::t_cnt r_stable_ticks, n_stable_ticks;
    bdsl_pkg::t_cnt r_held_ticks, n_held_ticks;
    logic           r_hold, n_hold;
    logic           r_long_rep, n_long_rep;
    logic           short_pulse;
    logic           long_pulse;
    bdsl_pkg::t_cnt held_inc;

    always_comb begin
        held_inc       = r_hold ? bdsl_pkg::sat_inc(r_held_ticks) : r_held_ticks;
        n_held_ticks   = held_inc;
        n_stable_ticks = (i_raw != r_last_raw) ? '0 : bdsl_pkg::sat_inc(r_stable_ticks);
        n_last_raw     = i_raw;
        n_level        = r_level;
        n_hold         = r_hold;
        n_long_rep     = r_long_rep;
        short_pulse    = 1'b0;
        long_pulse     = 1'b0;
        if (bdsl_pkg::t_cmp'(n_stable_ticks) > bdsl_pkg::t_cmp'(i_cfg.debounce_ticks)) begin
            n_level = i_raw;
            if (!i_raw && r_level) begin
                // press edge
                n_held_ticks = '0;
                n_hold       = 1'b1;
                n_long_rep   = 1'b0;
            end else if (i_raw && !r_level) begin
                // release edge
                short_pulse = !r_long_rep && r_hold &&
                    (bdsl_pkg::t_cmp'(held_inc) < bdsl_pkg::t_cmp'(i_cfg.long_press_ticks));
                n_held_ticks = '0;
                n_hold       = 1'b0;
                n_long_rep   = 1'b0;
            end else if (!i_raw && r_hold) begin
                if (!r_long_rep &&
                    (bdsl_pkg::t_cmp'(held_inc) >= bdsl_pkg::t_cmp'(i_cfg.long_press_ticks))) begin
                    long_pulse = 1'b1;
                    n_long_rep = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b1;
            r_level        <= 1'b1;
            r_stable_ticks <= '0;
            r_held_ticks   <= '0;
            r_hold         <= 1'b0;
            r_long_rep     <= 1'b0;
        end else if (i_step) begin
            r_last_raw     <= n_last_raw;
            r_level        <= n_level;
            r_stable_ticks <= n_stable_ticks;
            r_held_ticks   <= n_held_ticks;
            r_hold         <= n_hold;
            r_long_rep     <= n_long_rep;
        end
    end

    assign o_evt.short_pulse = short_pulse;
    assign o_evt.long_pulse  = long_pulse;
    assign o_evt.level       = n_level;

    `BDSL_ASSERT_NOW(a_no_short_and_long, i_clk, i_rst_n, i_step, !(short_pulse && long_pulse))
    `BDSL_ASSERT_NOW(a_idle_timer_clear, i_clk, i_rst_n, !r_hold, r_held_ticks == '0)
    `BDSL_ASSERT_NOW(a_long_needs_hold, i_clk, i_rst_n, r_long_rep, r_hold)
    `BDSL_ASSERT_NEXT(a_long_sets_flag, i_clk, i_rst_n, i_step && long_pulse, r_long_rep)

endmodule

`default_nettype wire

/* src/button_debounce_short_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// debounces the button pins and reports short presses, long presses and the
// first held button
//
//   channel  | dir | word
//   i_in     | in  | raw_levels, one sample tick
//   o_out    | out | short_press, long_press, pressed_code
//   cfg port | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// a new word is taken every cycle while the output
// register is empty or being drained
// the per-button counters update and the result register loads at the same edge
// synchronous reset restores released levels, cleared timers, default config
// a stalled result holds the input off until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_short_long_press (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bdsl_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [bdsl_pkg::CFG_BITS-1:0]     i_cfg_data,
    bdsl_in_if.sink                        i_in,
    bdsl_out_if.source                     o_out
);

    bdsl_pkg::t_cfg       r_cfg;
    logic                 r_out_valid;
    bdsl_pkg::t_btn_vec   r_short, r_long;
    bdsl_pkg::t_code      r_code, n_code;
    bdsl_pkg::t_btn_vec   n_short, n_long, n_level;
    bdsl_pkg::t_btn_evt   evt [bdsl_pkg::BUTTONS];
    logic                 step;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bdsl_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= bdsl_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdsl_pkg::CFG_DEBOUNCE:   r_cfg.debounce_ticks   <= i_cfg_data;
                bdsl_pkg::CFG_LONG_PRESS: r_cfg.long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < bdsl_pkg::BUTTONS; g++) begin : g_btn
        bdsl_button u_btn (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step),
            .i_raw   (i_in.raw_levels[g]),
            .i_cfg   (r_cfg),
            .o_evt   (evt[g])
        );
        assign n_short[g] = evt[g].short_pulse;
        assign n_long[g]  = evt[g].long_pulse;
        assign n_level[g] = evt[g].level;
    end

    // lowest pressed button wins
    always_comb begin
        n_code = bdsl_pkg::CODE_NONE;
        for (int b = bdsl_pkg::BUTTONS - 1; b >= 0; b--) begin
            if (b < bdsl_pkg::CODED_BUTTONS && !n_level[b]) begin
                n_code = bdsl_pkg::t_code'(b + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_short <= n_short;
            r_long  <= n_long;
            r_code  <= n_code;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.short_press  = r_short;
    assign o_out.long_press   = r_long;
    assign o_out.pressed_code = r_code;

endmodule

`default_nettype wire
